// ----- design/dda_line_rasterizer_unit_macros.svh -----
// Assertion macros for the DDA line rasterizer.
// Used by the top level; define ASSERT_OFF to compile them out.
`ifndef DDA_LINE_RASTERIZER_UNIT_MACROS_SVH
`define DDA_LINE_RASTERIZER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, masked while rst_n is low.
`define DLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also evaluated during reset.
`define DLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLR_ASSERT(lbl, prop, msg)
`define DLR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/dlr_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, types and codes for the DDA line rasterizer.
// No dependencies; the interfaces and all modules import it.
package dlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 24;

  // signed minor accumulator and slope, Q(FRAC_BITS)
  localparam int ACC_W   = COORD_BITS + FRAC_BITS + 2;
  localparam int SLOPE_W = FRAC_BITS + 2;

  // slope divider: divisor 2*den, quotient |slope| <= 2^FRAC_BITS
  localparam int DEN_W     = COORD_BITS + 1;
  localparam int QUOT_W    = FRAC_BITS + 1;
  localparam int NUM_W     = DEN_W + QUOT_W;
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [COLOR_BITS-1:0]    color_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SLOPE_W-1:0] slope_t;

  localparam coord_t COORD_MAX = '1;

  // input kind field
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_STEP,
    CMD_DROP
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   major_is_y;
    coord_t major_start;
    coord_t major_end;
    coord_t minor_start;
    logic   minor_neg;
    coord_t minor_mag;
    color_t color;
  } line_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIRST
  } bk_state_t;

  typedef struct packed {
    logic pop;
    logic push;
    logic push_last;
    logic line_active;
  } bk_status_t;

endpackage

// ----- design/dlr_in_if.sv -----
`timescale 1ns / 1ps
// Input item channel of the line rasterizer: valid/ready plus line fields.
// Depends on dlr_pkg.
interface dlr_in_if;
  import dlr_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t line_color;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

// ----- design/dlr_out_if.sv -----
`timescale 1ns / 1ps
// Pixel result channel of the line rasterizer: valid/ready plus pixel fields.
// Depends on dlr_pkg.
interface dlr_out_if;
  import dlr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  output ready);
endinterface

// ----- design/dlr_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input items, orders endpoints along the major axis
// and classifies each item as load, step or drop. Depends on dlr_pkg, dlr_in_if.
module dlr_front (
  dlr_in_if.sink            in_chan,
  output logic              push_valid,
  input  logic              push_ready,
  output dlr_pkg::line_cmd_t push_data
);
  import dlr_pkg::*;

  coord_t adx;
  coord_t ady;
  logic   major_y;
  coord_t mj0;
  coord_t mj1;
  coord_t mn0;
  coord_t mn1;

  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid;

  always_comb begin
    adx = (in_chan.end_x >= in_chan.start_x) ? in_chan.end_x - in_chan.start_x
                                             : in_chan.start_x - in_chan.end_x;
    ady = (in_chan.end_y >= in_chan.start_y) ? in_chan.end_y - in_chan.start_y
                                             : in_chan.start_y - in_chan.end_y;
    // ties go to y
    major_y = !(adx > ady);
    if (major_y) begin
      if (in_chan.start_y <= in_chan.end_y) begin
        mj0 = in_chan.start_y; mj1 = in_chan.end_y;
        mn0 = in_chan.start_x; mn1 = in_chan.end_x;
      end else begin
        mj0 = in_chan.end_y;   mj1 = in_chan.start_y;
        mn0 = in_chan.end_x;   mn1 = in_chan.start_x;
      end
    end else begin
      if (in_chan.start_x <= in_chan.end_x) begin
        mj0 = in_chan.start_x; mj1 = in_chan.end_x;
        mn0 = in_chan.start_y; mn1 = in_chan.end_y;
      end else begin
        mj0 = in_chan.end_x;   mj1 = in_chan.start_x;
        mn0 = in_chan.end_y;   mn1 = in_chan.start_y;
      end
    end

    push_data.major_is_y  = major_y;
    push_data.major_start = mj0;
    push_data.major_end   = mj1;
    push_data.minor_start = mn0;
    push_data.minor_neg   = (mn1 < mn0);
    push_data.minor_mag   = (mn1 < mn0) ? mn0 - mn1 : mn1 - mn0;
    push_data.color       = in_chan.line_color;

    if (in_chan.kind == KIND_STEP) begin
      push_data.cmd = CMD_STEP;
    end else if (adx == '0 && ady == '0) begin
      // single point: only kills the current line
      push_data.cmd = CMD_DROP;
    end else begin
      push_data.cmd = CMD_LOAD;
    end
  end

endmodule

// ----- design/dlr_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between front and back of the line rasterizer.
// Depends on dlr_pkg.
module dlr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  dlr_pkg::line_cmd_t push_data,
  output logic               pop_valid,
  input  logic               pop,
  output dlr_pkg::line_cmd_t pop_data
);
  import dlr_pkg::*;

  line_cmd_t            slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r,  count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/dlr_back.sv -----
`timescale 1ns / 1ps
// Back end: slope divider, line stepping state and the pixel output register.
// Depends on dlr_pkg, dlr_out_if.
module dlr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  dlr_pkg::line_cmd_t  q_data,
  output logic                q_pop,
  dlr_out_if.source           out_chan,
  output dlr_pkg::bk_status_t status
);
  import dlr_pkg::*;

  function automatic coord_t round_minor(acc_t acc);
    logic [ACC_W-1:0]          sum;
    logic [ACC_W-FRAC_BITS-1:0] whole;
    sum   = $unsigned(acc)
          + {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    whole = sum[ACC_W-1:FRAC_BITS];
    if (acc[ACC_W-1]) begin
      return '0;
    end else if (whole > (ACC_W - FRAC_BITS)'(COORD_MAX)) begin
      return COORD_MAX;
    end else begin
      return whole[COORD_BITS-1:0];
    end
  endfunction

  bk_state_t state_r, state_nxt;

  // line state
  logic   line_active_r, line_active_nxt;
  logic   major_is_y_r;
  coord_t pos_r;
  coord_t end_r;
  acc_t   acc_r;
  slope_t slope_r;
  color_t color_r;
  coord_t minor_start_r;
  logic   minor_neg_r;

  // divider
  logic [DEN_W-1:0]     rem_r;
  logic [QUOT_W-1:0]    numq_r;
  logic [DEN_W-1:0]     div_r;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  coord_t pixel_x_r;
  coord_t pixel_y_r;
  color_t pixel_color_r;
  logic   last_pixel_r;

  // control
  logic can_push;
  logic push;
  logic do_load;
  logic do_drop;
  logic do_step;
  logic do_first;
  logic do_div;

  // datapath
  coord_t           den;
  logic [NUM_W-1:0] num;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;
  slope_t           quot;
  slope_t           slope_new;
  acc_t             acc_start;
  coord_t           pos_step;
  acc_t             acc_step;
  logic             step_last;
  coord_t           minor_px;
  coord_t           pos_px;

  assign can_push = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_data.cmd == CMD_LOAD) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = BK_FIRST;
        end
      end
      BK_FIRST: begin
        if (can_push) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    push     = 1'b0;
    do_load  = 1'b0;
    do_drop  = 1'b0;
    do_step  = 1'b0;
    do_first = 1'b0;
    do_div   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_data.cmd)
            CMD_LOAD: begin
              q_pop   = 1'b1;
              do_load = 1'b1;
            end
            CMD_DROP: begin
              q_pop   = 1'b1;
              do_drop = 1'b1;
            end
            CMD_STEP: begin
              // drop a step while no line is active; otherwise wait for an output slot
              if (!line_active_r) begin
                q_pop = 1'b1;
              end else if (can_push) begin
                q_pop   = 1'b1;
                push    = 1'b1;
                do_step = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      BK_DIV: do_div = 1'b1;
      BK_FIRST: begin
        if (can_push) begin
          push     = 1'b1;
          do_first = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    den   = q_data.major_end - q_data.major_start;
    // numerator 2*|dmin|*2^FRAC_BITS + den, divisor 2*den
    num   = NUM_W'({q_data.minor_mag, {(FRAC_BITS + 1){1'b0}}}) + NUM_W'(den);
    trial = {rem_r, numq_r[QUOT_W-1]};
    ge    = (trial >= {1'b0, div_r});
    diff  = trial - {1'b0, div_r};

    quot      = slope_t'({1'b0, numq_r});
    slope_new = minor_neg_r ? -quot : quot;
    acc_start = {2'b00, minor_start_r, {FRAC_BITS{1'b0}}};

    pos_step  = pos_r + 1'b1;
    acc_step  = acc_r + {{(ACC_W - SLOPE_W){slope_r[SLOPE_W-1]}}, slope_r};
    step_last = (pos_step == end_r);

    if (do_first) begin
      minor_px = round_minor(acc_start);
      pos_px   = pos_r;
    end else begin
      minor_px = round_minor(acc_step);
      pos_px   = pos_step;
    end

    line_active_nxt = line_active_r;
    if (do_load || do_drop) begin
      line_active_nxt = 1'b0;
    end else if (do_first) begin
      line_active_nxt = 1'b1;
    end else if (do_step && step_last) begin
      line_active_nxt = 1'b0;
    end

    div_cnt_nxt = div_cnt_r;
    if (do_load) begin
      div_cnt_nxt = DIV_CNT_W'(QUOT_W - 1);
    end else if (do_div) begin
      div_cnt_nxt = div_cnt_r - 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      line_active_r <= 1'b0;
      div_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      line_active_r <= line_active_nxt;
      div_cnt_r     <= div_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      major_is_y_r  <= q_data.major_is_y;
      pos_r         <= q_data.major_start;
      end_r         <= q_data.major_end;
      minor_start_r <= q_data.minor_start;
      minor_neg_r   <= q_data.minor_neg;
      color_r       <= q_data.color;
      rem_r         <= num[NUM_W-1:QUOT_W];
      numq_r        <= num[QUOT_W-1:0];
      div_r         <= {den, 1'b0};
    end
    if (do_div) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      numq_r <= {numq_r[QUOT_W-2:0], ge};
    end
    if (do_first) begin
      acc_r   <= acc_start;
      slope_r <= slope_new;
    end
    if (do_step) begin
      acc_r <= acc_step;
      pos_r <= pos_step;
    end
    if (push) begin
      pixel_x_r     <= major_is_y_r ? minor_px : pos_px;
      pixel_y_r     <= major_is_y_r ? pos_px : minor_px;
      pixel_color_r <= color_r;
      last_pixel_r  <= do_step && step_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_x     = pixel_x_r;
  assign out_chan.pixel_y     = pixel_y_r;
  assign out_chan.pixel_color = pixel_color_r;
  assign out_chan.last_pixel  = last_pixel_r;

  assign status.pop         = q_pop;
  assign status.push        = push;
  assign status.push_last   = do_step && step_last;
  assign status.line_active = line_active_r;

endmodule

// ----- design/dda_line_rasterizer_unit.sv -----
`timescale 1ns / 1ps
// DDA line rasterizer (incremental line drawing, Q16 slope).
// Depends on dlr_pkg, dlr_in_if, dlr_out_if, dlr_front, dlr_queue, dlr_back.
//
// Usage: in_chan carries items under valid/ready. kind = 0 loads a line
// (two endpoints and a color) and yields its first pixel; kind = 1 yields the
// next pixel. out_chan carries pixels under valid/ready; last_pixel marks the
// far end of the line, after which step items give nothing until the next load.
// A load with equal endpoints gives no pixel and ends the current line.
// Throughput: step items give one pixel per cycle while out_chan.ready is high
// and no load is in progress; a step's pixel is registered in the queue, then in
// the output register. A load occupies the back end through its states in order:
// BK_IDLE takes it, BK_DIV runs the restoring slope divider at one quotient bit
// per cycle (FRAC_BITS + 1 bits), and BK_FIRST places the first pixel in the
// output register once an output slot is free.
// A two-entry command queue lets the front keep taking items while the
// divider runs or the receiver stalls; when out_chan.ready is low the output
// register holds its pixel and the queue fills, then in_chan.ready drops.
// Reset (rst_n low, synchronous) empties the queue and output register and
// leaves no line active.
`include "dda_line_rasterizer_unit_macros.svh"
module dda_line_rasterizer_unit (
  input logic       clk,
  input logic       rst_n,
  dlr_in_if.sink    in_chan,
  dlr_out_if.source out_chan
);
  import dlr_pkg::*;

  logic       push_valid;
  logic       push_ready;
  line_cmd_t  push_data;
  logic       q_valid;
  logic       q_pop;
  line_cmd_t  q_data;
  bk_status_t bk_status;

  // classify and order endpoints
  dlr_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouple front and back
  dlr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // divide, step and emit pixels
  dlr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_chan (out_chan),
    .status   (bk_status)
  );

  // no pixel may be presented right after reset
  `DLR_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_chan.valid, "out valid after reset")
  // an accepted item is in the queue on the next cycle
  `DLR_ASSERT(a_accept_queued, in_chan.valid && in_chan.ready |=> q_valid, "accepted item lost")
  // back end pops only what the queue holds
  `DLR_ASSERT(a_pop_nonempty, bk_status.pop |-> q_valid, "pop from empty queue")
  // the last pixel ends the line
  `DLR_ASSERT(a_last_ends_line, bk_status.push && bk_status.push_last |=> !bk_status.line_active, "line active after last pixel")

endmodule
